FILE: sv/angle_bias_kalman_filter_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the angle and gyro bias Kalman filter
// Shared forms for concurrent checks on the filter logic.
// ---------------------------------------------------------------------------
`ifndef ANGLE_BIAS_KALMAN_FILTER_MACROS_SVH
`define ANGLE_BIAS_KALMAN_FILTER_MACROS_SVH

// same-cycle implication
`define ABKF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("abkf: same-cycle check failed");

// next-cycle implication
`define ABKF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("abkf: next-cycle check failed");

`endif

FILE: sv/abkf_pkg.sv
// ---------------------------------------------------------------------------
// abkf_pkg
// Shared types and codes of the angle and gyro bias Kalman filter.
// ---------------------------------------------------------------------------
package abkf_pkg;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    typedef enum logic [3:0] {
        D_NONE,
        D_RATE,
        D_ANG,
        D_TP,
        D_P0,
        D_P1,
        D_P2,
        D_P3,
        D_INNER,
        D_S,
        D_Y,
        D_BIAS
    } t_dst;

    typedef struct packed {
        logic busy;
        logic done;
        logic clip;
    } t_div_status;

    localparam logic [1:0] REG_Q_ANGLE       = 2'd0;
    localparam logic [1:0] REG_Q_BIAS        = 2'd1;
    localparam logic [1:0] REG_R_MEASURE     = 2'd2;
    localparam logic [1:0] REG_INITIAL_ANGLE = 2'd3;

    localparam logic [4:0] STEP_DIV_K0 = 5'd13;
    localparam logic [4:0] STEP_DIV_K1 = 5'd14;
    localparam logic [4:0] STEP_LAST   = 5'd22;

    localparam logic [30:0] Q_ANGLE_RST   = 31'd1049;
    localparam logic [30:0] Q_BIAS_RST    = 31'd3146;
    localparam logic [30:0] R_MEASURE_RST = 31'd31457;

endpackage

FILE: sv/angle_bias_kalman_filter.sv
// ---------------------------------------------------------------------------
// angle_bias_kalman_filter
// Two-state Kalman filter for angle and gyro bias on a shared multiplier,
// a saturating adder and a serial divider under a step sequencer.
// ---------------------------------------------------------------------------
// Flow: no new word is taken while one is in work or while a finished result
// is held back.
// Reset: synchronous, active low; estimates and covariance clear, registers
// take their default values.
module angle_bias_kalman_filter #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // measured_angle, measured_rate, time_step, zero fill
    input  logic [((2*DATA_WIDTH+FRAC_BITS+1+7)/8)*8-1:0] s_axis_tdata,
    // restart
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // filtered_angle, unbiased_rate, bias_estimate
    output logic [((3*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // saturated
    output logic                  m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [DATA_WIDTH-1:0] i_cfg_data
);
    `include "angle_bias_kalman_filter_macros.svh"

    localparam int DW  = DATA_WIDTH;
    localparam int TW  = FRAC_BITS + 1;
    localparam int OTW = ((3*DATA_WIDTH+7)/8)*8;
    localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

    abkf_pkg::t_state r_state;
    logic [4:0]       r_step;

    logic [DW-2:0]        r_qa;
    logic [DW-2:0]        r_qb;
    logic [DW-2:0]        r_rm;
    logic signed [DW-1:0] r_init;

    logic signed [DW-1:0] r_meas, r_rin, r_rate, r_ang, r_bias, r_tp, r_inner;
    logic signed [DW-1:0] r_s, r_y, r_k0, r_k1, r_p0, r_p1, r_p2, r_p3;
    logic [TW-1:0]        r_t;
    logic                 r_clip;

    logic                 r_ovalid;
    logic [OTW-1:0]       r_odata;
    logic                 r_osat;

    logic signed [DW-1:0] w_t;
    logic signed [DW-1:0] w_mul_a, w_mul_b, w_mo;
    logic                 w_mclip;
    logic                 w_use_mo;
    logic signed [DW-1:0] w_add_a, w_add_b, w_sum;
    logic                 w_sub, w_aclip;
    logic [DW:0]          w_raw;
    abkf_pkg::t_dst       w_dst;
    logic                 w_div_go;
    logic signed [DW-1:0] w_div_num, w_div_res;
    abkf_pkg::t_div_status w_div_st;
    logic                 w_in_acc;
    logic                 w_out_go;

    assign w_t           = DW'(r_t);
    assign s_axis_tready = r_state == abkf_pkg::S_IDLE;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_osat;
    assign w_out_go      = (r_state == abkf_pkg::S_OUT) && (!r_ovalid || m_axis_tready);

    abkf_mul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_res  (w_mo),
        .o_clip (w_mclip)
    );

    assign w_div_num = (r_step == abkf_pkg::STEP_DIV_K0) ? r_p0 : r_p2;

    abkf_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_go),
        .i_num    (w_div_num),
        .i_den    (r_s),
        .o_res    (w_div_res),
        .o_status (w_div_st)
    );

    always_comb begin
        w_mul_a  = w_t;
        w_mul_b  = r_rate;
        w_add_a  = '0;
        w_add_b  = '0;
        w_sub    = 1'b0;
        w_use_mo = 1'b0;
        w_dst    = abkf_pkg::D_NONE;
        w_div_go = 1'b0;
        if (r_state == abkf_pkg::S_RUN) begin
            unique case (r_step)
                5'd0: begin
                    w_dst = abkf_pkg::D_RATE; w_add_a = r_rin; w_add_b = r_bias; w_sub = 1'b1;
                end
                5'd1: begin
                    w_mul_a = w_t; w_mul_b = r_rate;
                end
                5'd2: begin
                    w_dst = abkf_pkg::D_ANG; w_add_a = r_ang; w_add_b = w_mo; w_use_mo = 1'b1;
                    w_mul_a = w_t; w_mul_b = r_p3;
                end
                5'd3: begin
                    w_dst = abkf_pkg::D_TP; w_add_a = w_mo; w_use_mo = 1'b1;
                    w_mul_a = DW'(r_qb); w_mul_b = w_t;
                end
                5'd4: begin
                    w_dst = abkf_pkg::D_P3; w_add_a = r_p3; w_add_b = w_mo; w_use_mo = 1'b1;
                end
                5'd5: begin
                    w_dst = abkf_pkg::D_INNER; w_add_a = r_tp; w_add_b = r_p1; w_sub = 1'b1;
                end
                5'd6: begin
                    w_dst = abkf_pkg::D_INNER; w_add_a = r_inner; w_add_b = r_p2; w_sub = 1'b1;
                end
                5'd7: begin
                    w_dst = abkf_pkg::D_INNER; w_add_a = r_inner; w_add_b = DW'(r_qa);
                end
                5'd8: begin
                    w_mul_a = w_t; w_mul_b = r_inner;
                end
                5'd9: begin
                    w_dst = abkf_pkg::D_P0; w_add_a = r_p0; w_add_b = w_mo; w_use_mo = 1'b1;
                end
                5'd10: begin
                    w_dst = abkf_pkg::D_P1; w_add_a = r_p1; w_add_b = r_tp; w_sub = 1'b1;
                end
                5'd11: begin
                    w_dst = abkf_pkg::D_P2; w_add_a = r_p2; w_add_b = r_tp; w_sub = 1'b1;
                end
                5'd12: begin
                    w_dst = abkf_pkg::D_S; w_add_a = r_p0; w_add_b = DW'(r_rm);
                end
                abkf_pkg::STEP_DIV_K0, abkf_pkg::STEP_DIV_K1: begin
                    w_div_go = 1'b1;
                end
                5'd15: begin
                    w_dst = abkf_pkg::D_Y; w_add_a = r_meas; w_add_b = r_ang; w_sub = 1'b1;
                end
                5'd16: begin
                    w_mul_a = r_k0; w_mul_b = r_y;
                end
                5'd17: begin
                    w_dst = abkf_pkg::D_ANG; w_add_a = r_ang; w_add_b = w_mo; w_use_mo = 1'b1;
                    w_mul_a = r_k1; w_mul_b = r_y;
                end
                5'd18: begin
                    w_dst = abkf_pkg::D_BIAS; w_add_a = r_bias; w_add_b = w_mo;
                    w_use_mo = 1'b1; w_mul_a = r_k1; w_mul_b = r_p0;
                end
                5'd19: begin
                    w_dst = abkf_pkg::D_P2; w_add_a = r_p2; w_add_b = w_mo; w_sub = 1'b1;
                    w_use_mo = 1'b1; w_mul_a = r_k1; w_mul_b = r_p1;
                end
                5'd20: begin
                    w_dst = abkf_pkg::D_P3; w_add_a = r_p3; w_add_b = w_mo; w_sub = 1'b1;
                    w_use_mo = 1'b1; w_mul_a = r_k0; w_mul_b = r_p1;
                end
                5'd21: begin
                    w_dst = abkf_pkg::D_P1; w_add_a = r_p1; w_add_b = w_mo; w_sub = 1'b1;
                    w_use_mo = 1'b1; w_mul_a = r_k0; w_mul_b = r_p0;
                end
                abkf_pkg::STEP_LAST: begin
                    w_dst = abkf_pkg::D_P0; w_add_a = r_p0; w_add_b = w_mo; w_sub = 1'b1;
                    w_use_mo = 1'b1;
                end
                default: begin
                    w_dst = abkf_pkg::D_NONE;
                end
            endcase
        end
    end

    always_comb begin
        w_raw   = w_sub ? {w_add_a[DW-1], w_add_a} - {w_add_b[DW-1], w_add_b}
                        : {w_add_a[DW-1], w_add_a} + {w_add_b[DW-1], w_add_b};
        w_aclip = w_raw[DW] != w_raw[DW-1];
        w_sum   = w_aclip ? (w_raw[DW] ? DMIN : DMAX) : w_raw[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa   <= (DW-1)'(abkf_pkg::Q_ANGLE_RST);
            r_qb   <= (DW-1)'(abkf_pkg::Q_BIAS_RST);
            r_rm   <= (DW-1)'(abkf_pkg::R_MEASURE_RST);
            r_init <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                abkf_pkg::REG_Q_ANGLE:       r_qa   <= i_cfg_data[DW-2:0];
                abkf_pkg::REG_Q_BIAS:        r_qb   <= i_cfg_data[DW-2:0];
                abkf_pkg::REG_R_MEASURE:     r_rm   <= i_cfg_data[DW-2:0];
                abkf_pkg::REG_INITIAL_ANGLE: r_init <= i_cfg_data;
                default:                     r_init <= r_init;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= abkf_pkg::S_IDLE;
            r_step   <= '0;
            r_ovalid <= 1'b0;
            r_ang    <= '0;
            r_bias   <= '0;
            r_p0     <= '0;
            r_p1     <= '0;
            r_p2     <= '0;
            r_p3     <= '0;
            r_clip   <= 1'b0;
        end else begin
            if (w_out_go) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                abkf_pkg::S_IDLE: begin
                    if (w_in_acc) begin
                        r_meas  <= s_axis_tdata[DW-1:0];
                        r_rin   <= s_axis_tdata[2*DW-1:DW];
                        r_t     <= s_axis_tdata[2*DW+TW-1:2*DW];
                        r_clip  <= 1'b0;
                        r_step  <= '0;
                        r_state <= abkf_pkg::S_RUN;
                        if (s_axis_tuser) begin
                            r_ang  <= r_init;
                            r_bias <= '0;
                            r_p0   <= '0;
                            r_p1   <= '0;
                            r_p2   <= '0;
                            r_p3   <= '0;
                        end
                    end
                end
                abkf_pkg::S_RUN: begin
                    if ((w_dst != abkf_pkg::D_NONE && w_aclip) || (w_use_mo && w_mclip)) begin
                        r_clip <= 1'b1;
                    end
                    unique case (w_dst)
                        abkf_pkg::D_RATE:  r_rate  <= w_sum;
                        abkf_pkg::D_ANG:   r_ang   <= w_sum;
                        abkf_pkg::D_TP:    r_tp    <= w_sum;
                        abkf_pkg::D_P0:    r_p0    <= w_sum;
                        abkf_pkg::D_P1:    r_p1    <= w_sum;
                        abkf_pkg::D_P2:    r_p2    <= w_sum;
                        abkf_pkg::D_P3:    r_p3    <= w_sum;
                        abkf_pkg::D_INNER: r_inner <= w_sum;
                        abkf_pkg::D_S:     r_s     <= w_sum;
                        abkf_pkg::D_Y:     r_y     <= w_sum;
                        abkf_pkg::D_BIAS:  r_bias  <= w_sum;
                        default:           r_tp    <= r_tp;
                    endcase
                    if (w_div_go) begin
                        r_state <= abkf_pkg::S_DIV;
                    end else if (r_step == abkf_pkg::STEP_LAST) begin
                        r_state <= abkf_pkg::S_OUT;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                abkf_pkg::S_DIV: begin
                    if (w_div_st.done) begin
                        if (r_step == abkf_pkg::STEP_DIV_K0) begin
                            r_k0 <= w_div_res;
                        end else begin
                            r_k1 <= w_div_res;
                        end
                        if (w_div_st.clip) begin
                            r_clip <= 1'b1;
                        end
                        r_step  <= r_step + 1'b1;
                        r_state <= abkf_pkg::S_RUN;
                    end
                end
                abkf_pkg::S_OUT: begin
                    if (w_out_go) begin
                        r_state <= abkf_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= abkf_pkg::S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_go) begin
            r_odata <= OTW'({r_bias, r_rate, r_ang});
            r_osat  <= r_clip;
        end
    end

    `ABKF_ASSERT_IMP(a_div_busy_in_div, i_clk, i_rst_n, w_div_st.busy, r_state == abkf_pkg::S_DIV)
    `ABKF_ASSERT_IMP(a_step_bound, i_clk, i_rst_n, r_state == abkf_pkg::S_RUN, r_step <= abkf_pkg::STEP_LAST)
    `ABKF_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, w_in_acc, r_state == abkf_pkg::S_RUN && r_step == '0)

endmodule

FILE: sv/abkf_mul.sv
// ---------------------------------------------------------------------------
// abkf_mul
// Shared fixed-point multiplier: registered magnitude product, then
// rounding half away from zero and saturation.
// ---------------------------------------------------------------------------
module abkf_mul #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 20
) (
    input  logic                         i_clk,
    input  logic signed [DATA_WIDTH-1:0] i_a,
    input  logic signed [DATA_WIDTH-1:0] i_b,
    output logic signed [DATA_WIDTH-1:0] o_res,
    output logic                         o_clip
);
    localparam int PW = 2 * DATA_WIDTH + 1;

    logic [DATA_WIDTH-1:0]   w_ma;
    logic [DATA_WIDTH-1:0]   w_mb;
    logic [2*DATA_WIDTH-1:0] r_prod;
    logic                    r_neg;
    logic [PW-1:0]           w_rnd;
    logic [PW-1:0]           w_lim;
    logic [PW-1:0]           w_mag;

    assign w_ma = i_a[DATA_WIDTH-1] ? (~i_a) + 1'b1 : i_a;
    assign w_mb = i_b[DATA_WIDTH-1] ? (~i_b) + 1'b1 : i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        r_neg  <= i_a[DATA_WIDTH-1] ^ i_b[DATA_WIDTH-1];
    end

    always_comb begin
        w_rnd  = ({1'b0, r_prod} + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        w_lim  = r_neg ? (PW'(1) << (DATA_WIDTH - 1)) : ((PW'(1) << (DATA_WIDTH - 1)) - 1'b1);
        o_clip = w_rnd > w_lim;
        w_mag  = o_clip ? w_lim : w_rnd;
        o_res  = r_neg ? DATA_WIDTH'((~w_mag) + 1'b1) : w_mag[DATA_WIDTH-1:0];
    end

endmodule

FILE: sv/abkf_div.sv
// ---------------------------------------------------------------------------
// abkf_div
// Serial restoring divider for (n << FRAC_BITS) / d, one quotient bit
// per cycle, truncated toward zero and saturated.
// ---------------------------------------------------------------------------
module abkf_div #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DATA_WIDTH-1:0] i_num,
    input  logic signed [DATA_WIDTH-1:0] i_den,
    output logic signed [DATA_WIDTH-1:0] o_res,
    output abkf_pkg::t_div_status        o_status
);
    localparam int QW = DATA_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(QW + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [QW-1:0]         r_num;
    logic [QW-1:0]         r_q;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_ud;
    logic                  r_neg;
    logic                  r_nz;
    logic [DATA_WIDTH-1:0] w_un;
    logic [DATA_WIDTH-1:0] w_ud;
    logic [DATA_WIDTH:0]   w_sh;
    logic                  w_ge;
    logic [QW-1:0]         w_lim;
    logic [QW-1:0]         w_mag;
    logic                  w_clip;

    assign w_un = i_num[DATA_WIDTH-1] ? (~i_num) + 1'b1 : i_num;
    assign w_ud = i_den[DATA_WIDTH-1] ? (~i_den) + 1'b1 : i_den;
    assign w_sh = {r_rem, r_num[QW-1]};
    assign w_ge = w_sh >= {1'b0, r_ud};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {w_un, {FRAC_BITS{1'b0}}};
            r_q   <= '0;
            r_rem <= '0;
            r_ud  <= w_ud;
            r_neg <= i_num[DATA_WIDTH-1] ^ i_den[DATA_WIDTH-1];
            r_nz  <= w_un != '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_q   <= {r_q[QW-2:0], w_ge};
            r_rem <= w_ge ? DATA_WIDTH'(w_sh - {1'b0, r_ud}) : w_sh[DATA_WIDTH-1:0];
        end
    end

    always_comb begin
        w_lim  = r_neg ? (QW'(1) << (DATA_WIDTH - 1)) : ((QW'(1) << (DATA_WIDTH - 1)) - 1'b1);
        w_clip = r_nz && (r_q > w_lim);
        w_mag  = !r_nz ? '0 : (w_clip ? w_lim : r_q);
        o_res  = r_neg ? DATA_WIDTH'((~w_mag) + 1'b1) : w_mag[DATA_WIDTH-1:0];
        o_status.busy = r_busy;
        o_status.done = r_done;
        o_status.clip = w_clip;
    end

endmodule
